FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types for the sorted priority queue: controller states and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Request codes on the op field
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_PUT,
		S_REM_SHIFT,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic put;
		logic shift;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic one;
		logic le;
		logic idx_one;
		logic idx_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/spq_controller.sv
// ----------------------------------------------------------------------------
// spq_controller
// State machine that sequences one request at a time: the insert scan from
// the tail, the final placement, the removal shift and the result hand-off.
// ----------------------------------------------------------------------------
module spq_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  spq_pkg::status_t status,
	output spq_pkg::cmd_t    cmd
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_next;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Choose the next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (status.op == OP_INSERT) begin
						if (status.full) begin
							state_next = S_RESP;
						end else if (status.empty) begin
							state_next = S_INS_PUT;
						end else begin
							state_next = S_INS_SCAN;
						end
					end else begin
						if (status.empty || status.one) begin
							state_next = S_RESP;
						end else begin
							state_next = S_REM_SHIFT;
						end
					end
				end
			end
			S_INS_SCAN: begin
				if (!status.le) begin
					state_next = S_RESP;
				end else if (status.idx_one) begin
					state_next = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				state_next = S_RESP;
			end
			S_REM_SHIFT: begin
				if (status.idx_last) begin
					state_next = S_RESP;
				end
			end
			S_RESP: begin
				if (status.out_free) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Drive commands for the current state
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_INS_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_INS_PUT: begin
				cmd.put = 1'b1;
			end
			S_REM_SHIFT: begin
				cmd.shift = 1'b1;
			end
			S_RESP: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted value memory, count and top registers, scan pointer and the result
// register. Acts on controller commands and reports compare results back.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cmd_t      cmd,
	output spq_pkg::status_t   status,
	input  logic               in_valid,
	input  logic               op,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] removed_value,
	output logic               removed_valid,
	output logic               error,
	output logic signed [31:0] top_value,
	output logic [4:0]         count,
	output logic               empty_res
);
	import spq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CX = (CW > 5) ? CW : 5;

	logic signed [31:0] mem_q [CAPACITY];
	logic signed [31:0] rdata_q;
	logic signed [31:0] val_q;
	logic signed [31:0] top_q;
	logic signed [31:0] removed_q;
	logic               rvalid_q;
	logic               err_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;

	logic               wen;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [AW-1:0]      raddr;
	logic               full;
	logic               empty;
	logic               le;
	logic [CX-1:0]      count_x;

	logic               out_valid_q;
	logic signed [31:0] out_removed_q;
	logic               out_rvalid_q;
	logic               out_err_q;
	logic signed [31:0] out_top_q;
	logic [4:0]         out_count_q;
	logic               out_empty_q;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign le    = (rdata_q <= val_q);

	// Report status to the controller
	always_comb begin
		status          = '0;
		status.op       = op;
		status.full     = full;
		status.empty    = empty;
		status.one      = (count_q == CW'(1));
		status.le       = le;
		status.idx_one  = (idx_q == AW'(1));
		status.idx_last = (CW'(idx_q) == count_q);
		status.out_free = !out_valid_q || out_ready;
	end

	// Select the memory write port
	always_comb begin
		wen   = cmd.scan || cmd.put || cmd.shift;
		waddr = idx_q;
		wdata = val_q;
		if (cmd.scan) begin
			wdata = le ? rdata_q : val_q;
		end else if (cmd.shift) begin
			waddr = idx_q - AW'(1);
			wdata = rdata_q;
		end
	end

	// Select the memory read address, one entry ahead of the walk
	always_comb begin
		raddr = idx_q;
		if (cmd.accept) begin
			raddr = (op == OP_REMOVE) ? AW'(1) : AW'(count_q - CW'(1));
		end else if (cmd.scan) begin
			raddr = idx_q - AW'(2);
		end else if (cmd.shift) begin
			raddr = idx_q + AW'(1);
		end
	end

	// Sorted value memory with registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// Latch the request and update bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			if (op == OP_INSERT) begin
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (!empty) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Hold request payload, top value and walk pointer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q     <= value;
			err_q     <= 1'b0;
			rvalid_q  <= 1'b0;
			removed_q <= '0;
			if (op == OP_INSERT) begin
				if (full) begin
					err_q <= 1'b1;
				end else begin
					idx_q <= AW'(count_q);
					if (empty || value > top_q) begin
						top_q <= value;
					end
				end
			end else if (empty) begin
				err_q <= 1'b1;
			end else begin
				removed_q <= top_q;
				rvalid_q  <= 1'b1;
				idx_q     <= AW'(1);
			end
		end else if (cmd.scan) begin
			if (le) begin
				idx_q <= idx_q - AW'(1);
			end
		end else if (cmd.shift) begin
			idx_q <= idx_q + AW'(1);
			if (idx_q == AW'(1)) begin
				top_q <= rdata_q;
			end
		end
	end

	assign count_x = CX'(count_q);

	// Result register: load on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_removed_q <= removed_q;
			out_rvalid_q  <= rvalid_q;
			out_err_q     <= err_q;
			out_top_q     <= empty ? '0 : top_q;
			out_count_q   <= count_x[4:0];
			out_empty_q   <= empty;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = out_removed_q;
	assign removed_valid = out_rvalid_q;
	assign error         = out_err_q;
	assign top_value     = out_top_q;
	assign count         = out_count_q;
	assign empty_res     = out_empty_q;

	// Count never runs past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count exceeds capacity");

	// A result never reports both a removal and an error
	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_rvalid_q && out_err_q))
		else $error("removed_valid and error both set");

	// An empty queue reports a zero top value
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> (out_top_q == '0))
		else $error("empty result with nonzero top");

	// A removal from a nonempty queue drops the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && in_valid && op == OP_REMOVE && !empty)
			|=> (count_q == $past(count_q) - CW'(1)))
		else $error("removal did not decrement count");

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Max priority queue kept as a descending sorted list in a memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): op selects insert (0) or remove
//   largest (1); value is the value to insert. One request is worked on at
//   a time; in_ready is high only while the unit is idle.
//   Result channel (out_valid/out_ready): one result per request with the
//   removed value, its valid flag, an error flag (insert when full, remove
//   when empty), the top value, the count and an empty flag.
//   Steps: an error goes straight to the result step; an insert into an
//   empty queue places the value directly; other inserts walk from the
//   tail, moving each stored value at or below the new one back a place, and
//   a removal shifts the rest up. The walk moves one memory entry per cycle over the single write port.
//   Results go to an output register, so the next request is taken while a
//   result still waits; a stalled receiver holds the unit in its final step.
//   Reset empties the queue at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] removed_value,
	output logic               removed_valid,
	output logic               error,
	output logic signed [31:0] top_value,
	output logic [4:0]         count,
	output logic               empty_res
);
	import spq_pkg::*;

	cmd_t    cmd;
	status_t status;

	spq_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_valid      (in_valid),
		.op            (op),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.removed_valid (removed_valid),
		.error         (error),
		.top_value     (top_value),
		.count         (count),
		.empty_res     (empty_res)
	);

endmodule
